### rtl/ahe_pkg.sv
// Package for the adaptive Huffman encoder.
// Holds the sequencer state type and the beat type between the tree core and the bit packer.
// No dependencies.
package ahe_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_PCHK,
        S_PPAR,
        S_PRGT,
        S_EMIT_RD,
        S_EMIT_BIT,
        S_RAW,
        S_FLUSH,
        S_END,
        S_CLEAR,
        S_SPLIT_Z,
        S_SPLIT_E,
        S_SPLIT_S,
        S_UCHK,
        S_UW,
        S_SCAN,
        S_LCHK,
        S_ANC,
        S_ANC_GOT,
        S_SW_A,
        S_SW_B,
        S_SW_WA,
        S_SW_WB,
        S_RL,
        S_BUMP,
        S_UP
    } ahe_state_t;

    typedef enum logic [1:0] {
        BEAT_BIT,
        BEAT_FLUSH,
        BEAT_END
    } ahe_beat_t;

    typedef struct packed {
        logic      valid;
        ahe_beat_t kind;
        logic      bit_val;
    } ahe_beat_req_t;

    localparam int BYTE_BITS = 8;

endpackage

### rtl/ahe_packer.sv
// Bit packer of the adaptive Huffman encoder: collects code bits MSB first into bytes.
// Holds back the newest byte so that the last byte of an item can be marked.
// Depends on ahe_pkg.
module ahe_packer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ahe_pkg::ahe_beat_req_t req,
    output logic                  req_ready,
    output logic [7:0]            code_byte,
    output logic                  last,
    output logic                  code_valid,
    input  logic                  code_ready
);

    logic [7:0] buf_reg;
    logic [7:0] buf_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [7:0] hold_reg;
    logic [7:0] hold_next;
    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       produce;
    logic       needs_out;
    logic       take;
    logic [7:0] new_byte;

    assign out_free = !out_valid_reg || code_ready;

    always_comb
    begin
        produce  = 1'b0;
        new_byte = {buf_reg[6:0], req.bit_val};
        unique case (req.kind)
            ahe_pkg::BEAT_BIT:
            begin
                produce  = (cnt_reg == 3'd7);
                new_byte = {buf_reg[6:0], req.bit_val};
            end
            ahe_pkg::BEAT_FLUSH:
            begin
                produce  = (cnt_reg != 3'd0);
                new_byte = buf_reg << (3'd0 - cnt_reg);
            end
            ahe_pkg::BEAT_END:
            begin
                produce  = 1'b0;
                new_byte = buf_reg;
            end
            default:
            begin
                produce  = 1'b0;
                new_byte = buf_reg;
            end
        endcase
    end

    assign needs_out = hold_valid_reg && (produce || (req.kind == ahe_pkg::BEAT_END));
    assign req_ready = !(needs_out && !out_free);
    assign take      = req.valid && req_ready;

    always_comb
    begin
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !code_ready;
        if (take)
        begin
            if (needs_out)
            begin
                out_byte_next  = hold_reg;
                out_last_next  = (req.kind == ahe_pkg::BEAT_END);
                out_valid_next = 1'b1;
            end
            unique case (req.kind)
                ahe_pkg::BEAT_BIT:
                begin
                    buf_next = new_byte;
                    cnt_next = cnt_reg + 3'd1;
                end
                ahe_pkg::BEAT_FLUSH:
                begin
                    buf_next = '0;
                    cnt_next = '0;
                end
                ahe_pkg::BEAT_END:
                begin
                    hold_valid_next = 1'b0;
                end
                default:
                begin
                    hold_valid_next = hold_valid_reg;
                end
            endcase
            if (produce)
            begin
                hold_next       = new_byte;
                hold_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign code_byte  = out_byte_reg;
    assign last       = out_last_reg;
    assign code_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_end_empties_hold: assert property (@(posedge clk) disable iff (!rst_n)
        take && (req.kind == ahe_pkg::BEAT_END) |=> !hold_valid_reg)
        else $error("held byte survived the end of an item");
    a_flush_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        take && (req.kind == ahe_pkg::BEAT_FLUSH) |=> (cnt_reg == 3'd0))
        else $error("bit count not cleared by a flush");
    a_full_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
        take && (req.kind == ahe_pkg::BEAT_BIT) && (cnt_reg == 3'd7) |=> hold_valid_reg)
        else $error("completed byte was not held");
`endif

endmodule

### rtl/ahe_core.sv
// Tree core of the adaptive Huffman encoder: node memories, symbol map, path stack
// and the sequencer that codes a symbol and updates the tree one memory access at a time.
// Depends on ahe_pkg.
module ahe_core #(
    parameter int SYMBOLS     = 256,
    parameter int NODES       = 513,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             symbol,
    input  logic                   end_of_stream,
    input  logic                   sym_valid,
    output logic                   sym_ready,
    output ahe_pkg::ahe_beat_req_t beat,
    input  logic                   beat_ready
);

    localparam int NW    = $clog2(NODES);
    localparam int SAW   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int STK_D = (NODES + 1) / 2;
    localparam int STK_AW = $clog2(STK_D);
    localparam logic [NW-1:0] ROOT = NW'(NODES - 1);
    localparam logic signed [NW:0] ROOT_S = (NW + 1)'(NODES - 1);
    localparam logic signed [NW:0] FREE_INIT = (NW + 1)'(NODES - 2);

    ahe_pkg::ahe_state_t state_reg;
    ahe_pkg::ahe_state_t state_next;

    logic [WEIGHT_BITS-1:0] mem_w    [NODES];
    logic [NW-1:0]          mem_par  [NODES];
    logic [NW-1:0]          mem_l    [NODES];
    logic [NW-1:0]          mem_r    [NODES];
    logic                   mem_leaf [NODES];
    logic [7:0]             mem_sym  [NODES];
    logic [NW-1:0]          map_mem  [SYMBOLS];
    logic                   stk_mem  [STK_D];

    logic [WEIGHT_BITS-1:0] rd_w_mem;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic [NW-1:0]          rd_par;
    logic [NW-1:0]          rd_l;
    logic [NW-1:0]          rd_r;
    logic                   rd_leaf;
    logic [7:0]             rd_sym;
    logic [NW-1:0]          map_q;
    logic                   stk_q;

    logic [NW-1:0]          rd_addr;
    logic [NW-1:0]          rd_addr_q;
    logic [NW-1:0]          wr_addr;
    logic                   we_w;
    logic                   we_par;
    logic                   we_l;
    logic                   we_r;
    logic                   we_leaf;
    logic                   we_sym;
    logic [WEIGHT_BITS-1:0] wr_w;
    logic [NW-1:0]          wr_par;
    logic [NW-1:0]          wr_l;
    logic [NW-1:0]          wr_r;
    logic                   wr_leaf;
    logic [7:0]             wr_sym;
    logic                   map_we;
    logic [SAW-1:0]         map_waddr;
    logic [NW-1:0]          map_wdata;
    logic [SAW-1:0]         map_raddr;
    logic                   stk_we;
    logic                   stk_wdata;
    logic [STK_AW-1:0]      stk_raddr;

    logic [SYMBOLS-1:0]     map_v_reg;
    logic [NW-1:0]          empty_reg;
    logic signed [NW:0]     nfree_reg;
    logic [WEIGHT_BITS-1:0] root_w_reg;

    logic [7:0]             sym_reg;
    logic                   eos_reg;
    logic                   known_reg;
    logic [NW-1:0]          walk_reg;
    logic [NW-1:0]          par_reg;
    logic [STK_AW-1:0]      len_reg;
    logic [2:0]             k_reg;
    logic [NW-1:0]          n_reg;
    logic [WEIGHT_BITS-1:0] wn_reg;
    logic signed [NW:0]     i_reg;
    logic                   scan_v_reg;
    logic [NW-1:0]          lead_reg;
    logic [NW-1:0]          b_reg;
    logic [NW-1:0]          target_reg;
    logic                   phase_reg;
    logic [WEIGHT_BITS-1:0] sa_w_reg;
    logic [NW-1:0]          sa_l_reg;
    logic [NW-1:0]          sa_r_reg;
    logic                   sa_leaf_reg;
    logic [7:0]             sa_sym_reg;
    logic [NW-1:0]          sb_l_reg;
    logic [NW-1:0]          sb_r_reg;
    logic                   sb_leaf_reg;
    logic [7:0]             sb_sym_reg;
    logic [1:0]             rl_reg;

    logic                   sym_ok;
    logic                   known_now;
    logic                   nfree_pos;
    logic                   issue;
    logic                   hit;
    logic [NW-1:0]          split_s;
    logic [NW-1:0]          split_e;
    logic [WEIGHT_BITS-1:0] wn_inc;
    logic [WEIGHT_BITS-1:0] root_inc;

    assign sym_ok    = ({1'b0, sym_reg} < 9'(SYMBOLS));
    assign known_now = sym_ok && map_v_reg[sym_reg[SAW-1:0]];
    assign nfree_pos = !nfree_reg[NW] && (nfree_reg != '0);
    assign issue     = (i_reg > nfree_reg);
    assign rd_w      = (rd_addr_q == ROOT) ? root_w_reg : rd_w_mem;
    assign hit       = scan_v_reg && (rd_w == wn_reg);
    assign split_s   = nfree_reg[NW-1:0];
    assign split_e   = split_s - NW'(1);
    assign wn_inc    = (wn_reg == '1) ? wn_reg : wn_reg + WEIGHT_BITS'(1);
    assign root_inc  = (root_w_reg == '1) ? root_w_reg : root_w_reg + WEIGHT_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (we_w)
        begin
            mem_w[wr_addr] <= wr_w;
        end
        if (we_par)
        begin
            mem_par[wr_addr] <= wr_par;
        end
        if (we_l)
        begin
            mem_l[wr_addr] <= wr_l;
        end
        if (we_r)
        begin
            mem_r[wr_addr] <= wr_r;
        end
        if (we_leaf)
        begin
            mem_leaf[wr_addr] <= wr_leaf;
        end
        if (we_sym)
        begin
            mem_sym[wr_addr] <= wr_sym;
        end
        rd_w_mem <= mem_w[rd_addr];
        rd_par   <= mem_par[rd_addr];
        rd_l     <= mem_l[rd_addr];
        rd_r     <= mem_r[rd_addr];
        rd_leaf  <= mem_leaf[rd_addr];
        rd_sym   <= mem_sym[rd_addr];
        rd_addr_q <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[len_reg] <= stk_wdata;
        end
        stk_q <= stk_mem[stk_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ahe_pkg::S_IDLE:
                if (sym_valid)
                begin
                    state_next = ahe_pkg::S_START;
                end
            ahe_pkg::S_START:
                state_next = ahe_pkg::S_PCHK;
            ahe_pkg::S_PCHK:
                state_next = (walk_reg == ROOT) ? ahe_pkg::S_EMIT_RD : ahe_pkg::S_PPAR;
            ahe_pkg::S_PPAR:
                state_next = ahe_pkg::S_PRGT;
            ahe_pkg::S_PRGT:
                state_next = ahe_pkg::S_PCHK;
            ahe_pkg::S_EMIT_RD:
                if (len_reg != '0)
                begin
                    state_next = ahe_pkg::S_EMIT_BIT;
                end
                else if (!known_reg)
                begin
                    state_next = ahe_pkg::S_RAW;
                end
                else
                begin
                    state_next = eos_reg ? ahe_pkg::S_FLUSH : ahe_pkg::S_END;
                end
            ahe_pkg::S_EMIT_BIT:
                if (beat_ready)
                begin
                    state_next = ahe_pkg::S_EMIT_RD;
                end
            ahe_pkg::S_RAW:
                if (beat_ready && (k_reg == 3'd0))
                begin
                    state_next = eos_reg ? ahe_pkg::S_FLUSH : ahe_pkg::S_END;
                end
            ahe_pkg::S_FLUSH:
                if (beat_ready)
                begin
                    state_next = ahe_pkg::S_END;
                end
            ahe_pkg::S_END:
                if (beat_ready)
                begin
                    if (eos_reg)
                    begin
                        state_next = ahe_pkg::S_CLEAR;
                    end
                    else if (known_reg)
                    begin
                        state_next = ahe_pkg::S_UCHK;
                    end
                    else if (sym_ok && nfree_pos)
                    begin
                        state_next = ahe_pkg::S_SPLIT_Z;
                    end
                    else
                    begin
                        state_next = ahe_pkg::S_IDLE;
                    end
                end
            ahe_pkg::S_CLEAR:
                state_next = ahe_pkg::S_IDLE;
            ahe_pkg::S_SPLIT_Z:
                state_next = ahe_pkg::S_SPLIT_E;
            ahe_pkg::S_SPLIT_E:
                state_next = ahe_pkg::S_SPLIT_S;
            ahe_pkg::S_SPLIT_S:
                state_next = ahe_pkg::S_UCHK;
            ahe_pkg::S_UCHK:
                state_next = (n_reg == ROOT) ? ahe_pkg::S_IDLE : ahe_pkg::S_UW;
            ahe_pkg::S_UW:
                state_next = ahe_pkg::S_SCAN;
            ahe_pkg::S_SCAN:
                if (hit || (!scan_v_reg && !issue))
                begin
                    state_next = ahe_pkg::S_LCHK;
                end
            ahe_pkg::S_LCHK:
                state_next = (lead_reg > n_reg) ? ahe_pkg::S_ANC : ahe_pkg::S_BUMP;
            ahe_pkg::S_ANC:
                if (b_reg != ROOT)
                begin
                    state_next = ahe_pkg::S_ANC_GOT;
                end
                else if (phase_reg)
                begin
                    state_next = ahe_pkg::S_SW_A;
                end
                else
                begin
                    state_next = ahe_pkg::S_ANC;
                end
            ahe_pkg::S_ANC_GOT:
                state_next = (rd_par == target_reg) ? ahe_pkg::S_BUMP : ahe_pkg::S_ANC;
            ahe_pkg::S_SW_A:
                state_next = ahe_pkg::S_SW_B;
            ahe_pkg::S_SW_B:
                state_next = ahe_pkg::S_SW_WA;
            ahe_pkg::S_SW_WA:
                state_next = ahe_pkg::S_SW_WB;
            ahe_pkg::S_SW_WB:
                state_next = ahe_pkg::S_RL;
            ahe_pkg::S_RL:
                if (rl_reg == 2'd3)
                begin
                    state_next = ahe_pkg::S_BUMP;
                end
            ahe_pkg::S_BUMP:
                state_next = ahe_pkg::S_UP;
            ahe_pkg::S_UP:
                state_next = ahe_pkg::S_UCHK;
            default:
                state_next = ahe_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        sym_ready     = 1'b0;
        beat.valid    = 1'b0;
        beat.kind     = ahe_pkg::BEAT_BIT;
        beat.bit_val  = 1'b0;
        rd_addr       = n_reg;
        wr_addr       = n_reg;
        we_w          = 1'b0;
        we_par        = 1'b0;
        we_l          = 1'b0;
        we_r          = 1'b0;
        we_leaf       = 1'b0;
        we_sym        = 1'b0;
        wr_w          = '0;
        wr_par        = '0;
        wr_l          = '0;
        wr_r          = '0;
        wr_leaf       = 1'b0;
        wr_sym        = '0;
        map_we        = 1'b0;
        map_waddr     = sym_reg[SAW-1:0];
        map_wdata     = n_reg;
        map_raddr     = symbol[SAW-1:0];
        stk_we        = 1'b0;
        stk_wdata     = (rd_r == walk_reg);
        stk_raddr     = len_reg - STK_AW'(1);
        unique case (state_reg)
            ahe_pkg::S_IDLE:
                sym_ready = 1'b1;
            ahe_pkg::S_PCHK:
                rd_addr = walk_reg;
            ahe_pkg::S_PPAR:
                rd_addr = rd_par;
            ahe_pkg::S_PRGT:
                stk_we = 1'b1;
            ahe_pkg::S_EMIT_BIT:
            begin
                beat.valid   = 1'b1;
                beat.kind    = ahe_pkg::BEAT_BIT;
                beat.bit_val = stk_q;
            end
            ahe_pkg::S_RAW:
            begin
                beat.valid   = 1'b1;
                beat.kind    = ahe_pkg::BEAT_BIT;
                beat.bit_val = sym_reg[k_reg];
            end
            ahe_pkg::S_FLUSH:
            begin
                beat.valid = 1'b1;
                beat.kind  = ahe_pkg::BEAT_FLUSH;
            end
            ahe_pkg::S_END:
            begin
                beat.valid = 1'b1;
                beat.kind  = ahe_pkg::BEAT_END;
            end
            ahe_pkg::S_SPLIT_Z:
            begin
                wr_addr = n_reg;
                we_l    = 1'b1;
                we_r    = 1'b1;
                we_leaf = 1'b1;
                wr_l    = split_e;
                wr_r    = split_s;
                wr_leaf = 1'b0;
            end
            ahe_pkg::S_SPLIT_E, ahe_pkg::S_SPLIT_S:
            begin
                wr_addr = (state_reg == ahe_pkg::S_SPLIT_E) ? split_e : split_s;
                we_w    = 1'b1;
                we_par  = 1'b1;
                we_l    = 1'b1;
                we_r    = 1'b1;
                we_leaf = 1'b1;
                we_sym  = 1'b1;
                wr_par  = n_reg;
                wr_leaf = 1'b1;
                if (state_reg == ahe_pkg::S_SPLIT_S)
                begin
                    wr_w      = WEIGHT_BITS'(1);
                    wr_sym    = sym_reg;
                    map_we    = 1'b1;
                    map_waddr = sym_reg[SAW-1:0];
                    map_wdata = split_s;
                end
            end
            ahe_pkg::S_UCHK:
                rd_addr = n_reg;
            ahe_pkg::S_SCAN:
                rd_addr = i_reg[NW-1:0];
            ahe_pkg::S_ANC:
                rd_addr = b_reg;
            ahe_pkg::S_SW_A:
                rd_addr = n_reg;
            ahe_pkg::S_SW_B:
                rd_addr = lead_reg;
            ahe_pkg::S_SW_WA:
            begin
                wr_addr = n_reg;
                we_w    = 1'b1;
                we_l    = 1'b1;
                we_r    = 1'b1;
                we_leaf = 1'b1;
                we_sym  = 1'b1;
                wr_w    = rd_w;
                wr_l    = rd_l;
                wr_r    = rd_r;
                wr_leaf = rd_leaf;
                wr_sym  = rd_sym;
            end
            ahe_pkg::S_SW_WB:
            begin
                wr_addr = lead_reg;
                we_w    = 1'b1;
                we_l    = 1'b1;
                we_r    = 1'b1;
                we_leaf = 1'b1;
                we_sym  = 1'b1;
                wr_w    = sa_w_reg;
                wr_l    = sa_l_reg;
                wr_r    = sa_r_reg;
                wr_leaf = sa_leaf_reg;
                wr_sym  = sa_sym_reg;
            end
            ahe_pkg::S_RL:
            begin
                unique case (rl_reg)
                    2'd0:
                    begin
                        if (sb_leaf_reg)
                        begin
                            map_we    = (n_reg != empty_reg);
                            map_waddr = sb_sym_reg[SAW-1:0];
                            map_wdata = n_reg;
                        end
                        else
                        begin
                            we_par  = 1'b1;
                            wr_addr = sb_l_reg;
                            wr_par  = n_reg;
                        end
                    end
                    2'd1:
                    begin
                        we_par  = !sb_leaf_reg;
                        wr_addr = sb_r_reg;
                        wr_par  = n_reg;
                    end
                    2'd2:
                    begin
                        if (sa_leaf_reg)
                        begin
                            map_we    = (lead_reg != empty_reg);
                            map_waddr = sa_sym_reg[SAW-1:0];
                            map_wdata = lead_reg;
                        end
                        else
                        begin
                            we_par  = 1'b1;
                            wr_addr = sa_l_reg;
                            wr_par  = lead_reg;
                        end
                    end
                    default:
                    begin
                        we_par  = !sa_leaf_reg;
                        wr_addr = sa_r_reg;
                        wr_par  = lead_reg;
                    end
                endcase
            end
            ahe_pkg::S_BUMP:
            begin
                wr_addr = n_reg;
                we_w    = 1'b1;
                wr_w    = wn_inc;
                rd_addr = n_reg;
            end
            default:
            begin
                sym_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ahe_pkg::S_IDLE;
            map_v_reg  <= '0;
            empty_reg  <= ROOT;
            nfree_reg  <= FREE_INIT;
            root_w_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (map_we)
            begin
                map_v_reg[map_waddr] <= 1'b1;
            end
            unique case (state_reg)
                ahe_pkg::S_CLEAR:
                begin
                    map_v_reg  <= '0;
                    empty_reg  <= ROOT;
                    nfree_reg  <= FREE_INIT;
                    root_w_reg <= '0;
                end
                ahe_pkg::S_SPLIT_S:
                begin
                    empty_reg <= split_e;
                    nfree_reg <= nfree_reg - (NW + 1)'(2);
                end
                ahe_pkg::S_UCHK:
                    if (n_reg == ROOT)
                    begin
                        root_w_reg <= root_inc;
                    end
                ahe_pkg::S_SW_WA:
                    if (empty_reg == n_reg)
                    begin
                        empty_reg <= lead_reg;
                    end
                    else if (empty_reg == lead_reg)
                    begin
                        empty_reg <= n_reg;
                    end
                default:
                begin
                    empty_reg <= empty_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ahe_pkg::S_IDLE:
            begin
                sym_reg <= symbol;
                eos_reg <= end_of_stream;
            end
            ahe_pkg::S_START:
            begin
                known_reg <= known_now;
                walk_reg  <= known_now ? map_q : empty_reg;
                n_reg     <= known_now ? map_q : empty_reg;
                len_reg   <= '0;
                k_reg     <= 3'd7;
            end
            ahe_pkg::S_PPAR:
                par_reg <= rd_par;
            ahe_pkg::S_PRGT:
            begin
                len_reg  <= len_reg + STK_AW'(1);
                walk_reg <= par_reg;
            end
            ahe_pkg::S_EMIT_BIT:
                if (beat_ready)
                begin
                    len_reg <= len_reg - STK_AW'(1);
                end
            ahe_pkg::S_RAW:
                if (beat_ready)
                begin
                    k_reg <= k_reg - 3'd1;
                end
            ahe_pkg::S_UW:
            begin
                wn_reg     <= rd_w;
                i_reg      <= ROOT_S;
                scan_v_reg <= 1'b0;
            end
            ahe_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    lead_reg <= rd_addr_q;
                end
                else if (!scan_v_reg && !issue)
                begin
                    lead_reg <= n_reg;
                end
                i_reg      <= i_reg - (NW + 1)'(1);
                scan_v_reg <= issue;
            end
            ahe_pkg::S_LCHK:
            begin
                b_reg      <= n_reg;
                target_reg <= lead_reg;
                phase_reg  <= 1'b0;
            end
            ahe_pkg::S_ANC:
                if ((b_reg == ROOT) && !phase_reg)
                begin
                    b_reg      <= lead_reg;
                    target_reg <= n_reg;
                    phase_reg  <= 1'b1;
                end
            ahe_pkg::S_ANC_GOT:
                b_reg <= rd_par;
            ahe_pkg::S_SW_B:
            begin
                sa_w_reg    <= rd_w;
                sa_l_reg    <= rd_l;
                sa_r_reg    <= rd_r;
                sa_leaf_reg <= rd_leaf;
                sa_sym_reg  <= rd_sym;
            end
            ahe_pkg::S_SW_WA:
            begin
                sb_l_reg    <= rd_l;
                sb_r_reg    <= rd_r;
                sb_leaf_reg <= rd_leaf;
                sb_sym_reg  <= rd_sym;
                rl_reg      <= 2'd0;
            end
            ahe_pkg::S_RL:
            begin
                rl_reg <= rl_reg + 2'd1;
                if (rl_reg == 2'd3)
                begin
                    n_reg <= lead_reg;
                end
            end
            ahe_pkg::S_UP:
                n_reg <= rd_par;
            default:
            begin
                rl_reg <= rl_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_free_floor: assert property (@(posedge clk) disable iff (!rst_n)
        !(nfree_reg[NW] && (nfree_reg != '1)))
        else $error("free node number dropped below minus one");
    a_swap_upward: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ahe_pkg::S_SW_A) |-> (lead_reg > n_reg) && (lead_reg != ROOT))
        else $error("swap partner is not a higher non-root node");
    a_stack_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ahe_pkg::S_END) |-> (len_reg == '0))
        else $error("path stack not empty at the end of an item");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_ready |=> (state_reg == ahe_pkg::S_START) && !beat.valid)
        else $error("accepted symbol did not start the sequencer");
`endif

endmodule

### rtl/adaptive_huffman_encoder.sv
// FGK adaptive Huffman encoder, top level: one byte in, packed code bytes out.
// A symbol is coded by walking its root path of L bits; the tree update then takes, per tree level,
// an ancestor walk and a leader scan over the node weight memory, one node per cycle, which is
// the longest step. Reset is asynchronous and immediate; no clearing pass.
// Depends on ahe_pkg, ahe_core and ahe_packer.
module adaptive_huffman_encoder #(
    parameter int SYMBOLS     = 256,
    parameter int NODES       = 513,
    parameter int WEIGHT_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] symbol,
    input  logic       end_of_stream,
    input  logic       sym_valid,
    output logic       sym_ready,
    output logic [7:0] code_byte,
    output logic       last,
    output logic       code_valid,
    input  logic       code_ready
);

    ahe_pkg::ahe_beat_req_t beat;
    logic                   beat_ready;

    ahe_core #(
        .SYMBOLS     (SYMBOLS),
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .symbol        (symbol),
        .end_of_stream (end_of_stream),
        .sym_valid     (sym_valid),
        .sym_ready     (sym_ready),
        .beat          (beat),
        .beat_ready    (beat_ready)
    );

    ahe_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (beat),
        .req_ready  (beat_ready),
        .code_byte  (code_byte),
        .last       (last),
        .code_valid (code_valid),
        .code_ready (code_ready)
    );

endmodule
